// ===== hw/rtl/iida_pkg.sv =====
// ----------------------------------------------------------------------------
// iida_pkg
// Shared types and codes for the indexed insert/delete array: request and
// response transactions, status and request codes, cell control.
// ----------------------------------------------------------------------------
package iida_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH + 1);

	localparam logic [1:0] REQ_APPEND = 2'd0;
	localparam logic [1:0] REQ_INSERT = 2'd1;
	localparam logic [1:0] REQ_DELETE = 2'd2;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_RANGE = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [3:0]         position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] item_value;
		logic [3:0]         item_position;
		logic               list_empty;
		logic [4:0]         fill_count;
		logic               is_last;
	} rsp_t;

	typedef enum logic [2:0] {
		CELL_HOLD   = 3'd0,
		CELL_INSERT = 3'd1,
		CELL_DELETE = 3'd2,
		CELL_APPEND = 3'd3,
		CELL_ROTATE = 3'd4
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic [IDX_W-1:0]   sel;
		logic signed [31:0] value;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/iida_cell.sv =====
// ----------------------------------------------------------------------------
// iida_cell
// One storage cell of the array: takes its left or right neighbor, the new
// value, or the head of the chain, as the broadcast control selects.
// ----------------------------------------------------------------------------
module iida_cell #(
	parameter int IDX = 0
) (
	input  logic                      clk,
	input  iida_pkg::cell_ctl_t       ctl,
	input  logic signed [31:0]        left,
	input  logic signed [31:0]        right,
	input  logic signed [31:0]        first,
	output logic signed [31:0]        data
);

	localparam logic [iida_pkg::IDX_W-1:0] IDX_V = iida_pkg::IDX_W'(IDX);

	logic signed [31:0] data_q;
	logic signed [31:0] data_nxt;

	always_comb begin
		data_nxt = data_q;
		unique case (ctl.op)
			iida_pkg::CELL_HOLD: begin
			end
			iida_pkg::CELL_INSERT: begin
				if (IDX_V > ctl.sel) begin
					data_nxt = left;
				end else if (IDX_V == ctl.sel) begin
					data_nxt = ctl.value;
				end
			end
			iida_pkg::CELL_DELETE: begin
				if (IDX_V >= ctl.sel) begin
					data_nxt = right;
				end
			end
			iida_pkg::CELL_APPEND: begin
				if (IDX_V == ctl.sel) begin
					data_nxt = ctl.value;
				end
			end
			iida_pkg::CELL_ROTATE: begin
				if (IDX_V == ctl.sel) begin
					data_nxt = first;
				end else if (IDX_V < ctl.sel) begin
					data_nxt = right;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

	assign data = data_q;

endmodule

// ===== hw/rtl/indexed_insert_delete_array.sv =====
// ----------------------------------------------------------------------------
// indexed_insert_delete_array
// Ordered store of up to DEPTH signed values with append, insert and delete
// at an index; each request gets a read-out of the store or a status answer.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload        | direction
//  req     | req_valid / req_ready | iida_pkg::req_t | in
//  rsp     | rsp_valid / rsp_ready | iida_pkg::rsp_t | out
//
//  A request first updates the cell chain, then the store is read out one
//  value at a time (a single answer for an error or empty store). The
//  read-out rotates the first count cells toward cell 0, one position per
//  cycle while rsp is free. Reset clears the fill count and control
//  state but not the cells; no clearing pass. A stall on rsp holds the
//  rotation in place. req_ready is high while no read-out is in progress.
// ----------------------------------------------------------------------------
module indexed_insert_delete_array (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  iida_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output iida_pkg::rsp_t rsp
);

	localparam int CW    = $clog2(iida_pkg::DEPTH + 1);
	localparam int CMP_W = (CW > 4) ? CW : 4;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_READ   = 3'b010,
		ST_SINGLE = 3'b100
	} state_t;

	state_t               state_q;
	state_t               state_nxt;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        count_nxt;
	logic [CW-1:0]        rd_idx_q;
	logic [CW-1:0]        tail;
	logic [1:0]           status_q;
	logic [1:0]           status_nxt;
	iida_pkg::rsp_t       rsp_q;
	logic                 rsp_valid_q;
	logic                 rsp_free;
	logic                 req_fire;
	logic                 full;
	logic                 pos_bad;
	logic [1:0]           chk_status;
	logic                 rd_last;
	iida_pkg::cell_ctl_t  ctl;
	logic signed [31:0]   cell_data [iida_pkg::DEPTH];

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign full    = (count_q == CW'(iida_pkg::DEPTH));
	assign pos_bad = (CMP_W'(req.position) >= CMP_W'(count_q));
	assign tail    = count_q - CW'(1);
	assign rd_last = (rd_idx_q == tail);

	always_comb begin
		unique case (req.req_type)
			iida_pkg::REQ_APPEND: chk_status = full ? iida_pkg::STATUS_FULL : iida_pkg::STATUS_OK;
			iida_pkg::REQ_INSERT: chk_status = pos_bad ? iida_pkg::STATUS_RANGE :
				(full ? iida_pkg::STATUS_FULL : iida_pkg::STATUS_OK);
			iida_pkg::REQ_DELETE: chk_status = pos_bad ? iida_pkg::STATUS_RANGE :
				iida_pkg::STATUS_OK;
			default:              chk_status = iida_pkg::STATUS_RANGE;
		endcase
	end

	always_comb begin
		state_nxt  = state_q;
		count_nxt  = count_q;
		status_nxt = status_q;
		ctl.op     = iida_pkg::CELL_HOLD;
		ctl.sel    = iida_pkg::IDX_W'(count_q);
		ctl.value  = req.value;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					status_nxt = chk_status;
					if (chk_status == iida_pkg::STATUS_OK) begin
						unique case (req.req_type)
							iida_pkg::REQ_APPEND: begin
								ctl.op    = iida_pkg::CELL_APPEND;
								count_nxt = count_q + CW'(1);
							end
							iida_pkg::REQ_INSERT: begin
								ctl.op    = iida_pkg::CELL_INSERT;
								ctl.sel   = iida_pkg::IDX_W'(req.position);
								count_nxt = count_q + CW'(1);
							end
							default: begin
								ctl.op    = iida_pkg::CELL_DELETE;
								ctl.sel   = iida_pkg::IDX_W'(req.position);
								count_nxt = count_q - CW'(1);
							end
						endcase
						state_nxt = (count_nxt == '0) ? ST_SINGLE : ST_READ;
					end else begin
						state_nxt = ST_SINGLE;
					end
				end
			end
			ST_READ: begin
				if (rsp_free) begin
					ctl.op  = iida_pkg::CELL_ROTATE;
					ctl.sel = iida_pkg::IDX_W'(tail);
					if (rd_last) begin
						state_nxt = ST_IDLE;
					end
				end
			end
			ST_SINGLE: begin
				if (rsp_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	for (genvar i = 0; i < iida_pkg::DEPTH; i++) begin : g_cell
		logic signed [31:0] left_d;
		logic signed [31:0] right_d;
		if (i == 0) begin : g_head
			assign left_d = '0;
		end else begin : g_body
			assign left_d = cell_data[i-1];
		end
		if (i == iida_pkg::DEPTH - 1) begin : g_end
			assign right_d = '0;
		end else begin : g_mid
			assign right_d = cell_data[i+1];
		end
		iida_cell #(
			.IDX(i)
		) u_cell (
			.clk  (clk),
			.ctl  (ctl),
			.left (left_d),
			.right(right_d),
			.first(cell_data[0]),
			.data (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			status_q    <= iida_pkg::STATUS_OK;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			count_q  <= count_nxt;
			status_q <= status_nxt;
			if (state_q != ST_IDLE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (state_q == ST_IDLE) begin
				rd_idx_q <= '0;
			end else if (rsp_free) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ && rsp_free) begin
			rsp_q.status        <= iida_pkg::STATUS_OK;
			rsp_q.item_value    <= cell_data[0];
			rsp_q.item_position <= 4'(rd_idx_q);
			rsp_q.list_empty    <= 1'b0;
			rsp_q.fill_count    <= 5'(count_q);
			rsp_q.is_last       <= rd_last;
		end else if (state_q == ST_SINGLE && rsp_free) begin
			rsp_q.status        <= status_q;
			rsp_q.item_value    <= '0;
			rsp_q.item_position <= '0;
			rsp_q.list_empty    <= (count_q == '0);
			rsp_q.fill_count    <= 5'(count_q);
			rsp_q.is_last       <= 1'b1;
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(iida_pkg::DEPTH))
		else $error("fill count above depth");

	a_read_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> rd_idx_q < count_q)
		else $error("read index beyond fill count");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!req_fire |=> $stable(count_q))
		else $error("fill count changed without a request transaction");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> state_q != ST_IDLE)
		else $error("request transaction produced no response");
`endif

endmodule

// ===== tb/sv/indexed_insert_delete_array_test.sv =====
// ----------------------------------------------------------------------------
// indexed_insert_delete_array_test
// Drives append, insert and delete requests into the indexed store and checks
// every read-out transaction against a local copy of the store kept in step
// with accepted requests. Directed requests hit the empty and full edges, the
// bad positions and the reserved request code. Random requests follow a
// wandering fill target, so the store keeps filling and draining, with some
// noise mixed in. Both sides idle in bursts, and the receiver holds off once
// for a long stretch.
// ----------------------------------------------------------------------------
module indexed_insert_delete_array_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         STORE_DEPTH  = iida_pkg::DEPTH;
	localparam logic [1:0] REQ_RESERVED = 2'd3;
	localparam int         LONG_STALL   = 300;
	localparam int         CYCLE_LIMIT  = 400000;

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_ready;
	iida_pkg::req_t req       = '0;
	logic           rsp_valid;
	logic           rsp_ready = 1'b0;
	iida_pkg::rsp_t rsp;

	iida_pkg::req_t     pending_reqs[$];
	iida_pkg::rsp_t     expected_readout[$];
	iida_pkg::rsp_t     want_rsp;
	logic signed [31:0] model_cells[STORE_DEPTH];
	int                 model_count  = 0;
	int                 plan_count   = 0;
	int                 mismatches   = 0;
	int                 cycles       = 0;
	int                 tx_gap       = 0;
	int                 rx_gap       = 0;
	int                 stall_cycles = 0;
	bit                 idling_on    = 1'b1;
	bit                 stall_armed  = 1'b0;
	bit                 stall_done   = 1'b0;

	indexed_insert_delete_array u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void push_readout(logic [1:0] status);
		iida_pkg::rsp_t r;
		r               = '0;
		r.status        = status;
		r.list_empty    = (model_count == 0);
		r.fill_count    = 5'(model_count);
		r.is_last       = 1'b1;
		if (status != iida_pkg::STATUS_OK || model_count == 0) begin
			expected_readout.push_back(r);
		end else begin
			for (int i = 0; i < model_count; i++) begin
				r.item_value    = model_cells[i];
				r.item_position = 4'(i);
				r.is_last       = (i == model_count - 1);
				expected_readout.push_back(r);
			end
		end
	endfunction

	function automatic void apply_request(iida_pkg::req_t r);
		int p;
		p = r.position;
		case (r.req_type)
			iida_pkg::REQ_APPEND: begin
				if (model_count >= STORE_DEPTH) begin
					push_readout(iida_pkg::STATUS_FULL);
				end else begin
					model_cells[model_count] = r.value;
					model_count++;
					push_readout(iida_pkg::STATUS_OK);
				end
			end
			iida_pkg::REQ_INSERT: begin
				if (p >= model_count) begin
					push_readout(iida_pkg::STATUS_RANGE);
				end else if (model_count >= STORE_DEPTH) begin
					push_readout(iida_pkg::STATUS_FULL);
				end else begin
					for (int i = model_count; i > p; i--)
						model_cells[i] = model_cells[i - 1];
					model_cells[p] = r.value;
					model_count++;
					push_readout(iida_pkg::STATUS_OK);
				end
			end
			iida_pkg::REQ_DELETE: begin
				if (p >= model_count) begin
					push_readout(iida_pkg::STATUS_RANGE);
				end else begin
					for (int i = p; i + 1 < model_count; i++)
						model_cells[i] = model_cells[i + 1];
					model_count--;
					push_readout(iida_pkg::STATUS_OK);
				end
			end
			default: begin
				push_readout(iida_pkg::STATUS_RANGE);
			end
		endcase
	endfunction

	function automatic void enqueue_request(logic [1:0] kind, logic [3:0] pos,
			logic signed [31:0] val);
		iida_pkg::req_t r;
		r.req_type = kind;
		r.position = pos;
		r.value    = val;
		pending_reqs.push_back(r);
		case (kind)
			iida_pkg::REQ_APPEND: begin
				if (plan_count < STORE_DEPTH)
					plan_count++;
			end
			iida_pkg::REQ_INSERT: begin
				if (pos < plan_count && plan_count < STORE_DEPTH)
					plan_count++;
			end
			iida_pkg::REQ_DELETE: begin
				if (pos < plan_count)
					plan_count--;
			end
			default: begin
			end
		endcase
	endfunction

	task automatic queue_random(int n);
		int         target;
		int         roll;
		logic [1:0] kind;
		int         pos;
		target = 0;
		for (int k = 0; k < n; k++) begin
			if (k % 20 == 0)
				target = $urandom_range(0, STORE_DEPTH);
			roll = $urandom_range(0, 99);
			if (roll < 12) begin
				kind = 2'($urandom_range(0, 3));
				pos  = $urandom_range(0, 15);
			end else if (plan_count < target || plan_count == 0) begin
				kind = ($urandom_range(0, 1) && plan_count > 0) ?
					iida_pkg::REQ_INSERT : iida_pkg::REQ_APPEND;
				pos  = (plan_count > 0) ? $urandom_range(0, plan_count - 1) :
					$urandom_range(0, 15);
			end else begin
				kind = iida_pkg::REQ_DELETE;
				pos  = $urandom_range(0, plan_count - 1);
			end
			enqueue_request(kind, 4'(pos), $urandom());
		end
	endtask

	task automatic wait_for_readouts();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || req_valid || expected_readout.size() != 0);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
			tx_gap    <= 0;
		end else begin
			if (req_valid && req_ready)
				apply_request(req);
			if (!req_valid || req_ready) begin
				if (tx_gap > 0) begin
					tx_gap    <= tx_gap - 1;
					req_valid <= 1'b0;
				end else if (pending_reqs.size() == 0) begin
					req_valid <= 1'b0;
				end else if (idling_on && $urandom_range(0, 7) == 0) begin
					tx_gap    <= $urandom_range(0, 13);
					req_valid <= 1'b0;
				end else begin
					req       <= pending_reqs.pop_front();
					req_valid <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rx_gap    <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_readout.size() == 0) begin
					$error("unexpected transaction: status %0d value %0d position %0d",
						rsp.status, rsp.item_value, rsp.item_position);
					mismatches++;
				end else begin
					want_rsp = expected_readout.pop_front();
					if (rsp.status !== want_rsp.status) begin
						$error("status: expected %0d, got %0d", want_rsp.status, rsp.status);
						mismatches++;
					end
					if (rsp.item_value !== want_rsp.item_value) begin
						$error("item_value: expected %0d, got %0d",
							want_rsp.item_value, rsp.item_value);
						mismatches++;
					end
					if (rsp.item_position !== want_rsp.item_position) begin
						$error("item_position: expected %0d, got %0d",
							want_rsp.item_position, rsp.item_position);
						mismatches++;
					end
					if (rsp.list_empty !== want_rsp.list_empty) begin
						$error("list_empty: expected %0d, got %0d",
							want_rsp.list_empty, rsp.list_empty);
						mismatches++;
					end
					if (rsp.fill_count !== want_rsp.fill_count) begin
						$error("fill_count: expected %0d, got %0d",
							want_rsp.fill_count, rsp.fill_count);
						mismatches++;
					end
					if (rsp.is_last !== want_rsp.is_last) begin
						$error("is_last: expected %0d, got %0d", want_rsp.is_last, rsp.is_last);
						mismatches++;
					end
				end
			end
			if (stall_armed && !stall_done) begin
				rsp_ready    <= 1'b0;
				stall_cycles <= stall_cycles + 1;
				if (stall_cycles == LONG_STALL - 1)
					stall_done <= 1'b1;
			end else if (rx_gap > 0) begin
				rx_gap    <= rx_gap - 1;
				rsp_ready <= 1'b0;
			end else if (idling_on && $urandom_range(0, 9) == 0) begin
				rx_gap    <= $urandom_range(0, 13);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		enqueue_request(iida_pkg::REQ_DELETE, 4'd0, 32'sd5);
		enqueue_request(iida_pkg::REQ_INSERT, 4'd0, 32'sd7);
		enqueue_request(REQ_RESERVED, 4'd15, 32'sh7fffffff);
		enqueue_request(iida_pkg::REQ_APPEND, 4'd15, 32'sh7fffffff);
		enqueue_request(iida_pkg::REQ_APPEND, 4'd0, 32'sh80000000);
		enqueue_request(iida_pkg::REQ_INSERT, 4'd0, -32'sd1);
		enqueue_request(iida_pkg::REQ_INSERT, 4'd3, 32'sd9);
		enqueue_request(iida_pkg::REQ_DELETE, 4'd1, 32'sd0);
		enqueue_request(iida_pkg::REQ_DELETE, 4'd1, 32'sd0);
		enqueue_request(iida_pkg::REQ_DELETE, 4'd0, 32'sd0);
		for (int i = 0; i < STORE_DEPTH; i++)
			enqueue_request(iida_pkg::REQ_APPEND, 4'(i),
				(i % 2) ? 32'sh80000000 + i : 32'sh7fffffff - i);
		enqueue_request(iida_pkg::REQ_APPEND, 4'd0, 32'sd1);
		enqueue_request(iida_pkg::REQ_INSERT, 4'd15, 32'sd2);
		enqueue_request(iida_pkg::REQ_DELETE, 4'd15, 32'sd0);
		enqueue_request(iida_pkg::REQ_DELETE, 4'd0, 32'sd0);
		wait_for_readouts();

		stall_armed = 1'b1;
		queue_random(150);
		wait_for_readouts();

		queue_random(120);
		while (pending_reqs.size() != 0)
			@(negedge clk);
		idling_on = 1'b0;
		queue_random(60);
		wait_for_readouts();
		repeat (STORE_DEPTH + 4) @(posedge clk);

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/iida_pkg.sv
hw/rtl/iida_cell.sv
hw/rtl/indexed_insert_delete_array.sv
tb/sv/indexed_insert_delete_array_test.sv
